@@ hw/rtl/hkm_pkg.sv @@
// Package for the heap k-way merge block: state encoding, field widths and
// the heap ordering function. No dependencies; every other file but hkm_ram uses it.
package hkm_pkg;

  localparam int MAX_LISTS_DEF    = 8;
  localparam int MAX_ELEMENTS_DEF = 64;

  localparam int VALUE_W = 32;
  localparam int SRC_W   = 3;
  localparam int NUML_W  = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register addresses (byte address, bit 2 selects the register slot).
  localparam logic REG_NUM_LISTS = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLD_RD,
    ST_BLD_WR,
    ST_HEAPIFY,
    ST_SIFT,
    ST_MERGE,
    ST_LINK,
    ST_ELEM,
    ST_UPD
  } state_t;

  // True if entry a must sit above entry b: smaller value first, and on a
  // tie the lower list number.
  function automatic logic entry_before(input logic [VALUE_W-1:0] va,
                                        input logic [SRC_W-1:0]   sa,
                                        input logic [VALUE_W-1:0] vb,
                                        input logic [SRC_W-1:0]   sb);
    if (va != vb) begin
      return $signed(va) < $signed(vb);
    end
    return sa < sb;
  endfunction

endpackage

@@ hw/rtl/hkm_in_if.sv @@
// Input channel of the heap k-way merge block: valid/ready plus one element.
// Depends on hkm_pkg for the field widths.
interface hkm_in_if;
  logic                         valid;
  logic                         ready;
  logic [hkm_pkg::SRC_W-1:0]    list_id;
  logic [hkm_pkg::VALUE_W-1:0]  value;
  logic                         final_req;

  modport source (output valid, list_id, value, final_req, input ready);
  modport sink   (input valid, list_id, value, final_req, output ready);
endinterface

@@ hw/rtl/hkm_out_if.sv @@
// Output channel of the heap k-way merge block: valid/ready plus one result.
// Depends on hkm_pkg for the field widths.
interface hkm_out_if;
  logic                         valid;
  logic                         ready;
  logic [hkm_pkg::VALUE_W-1:0]  merged_value;
  logic [hkm_pkg::SRC_W-1:0]    source_list;
  logic                         last;
  logic                         overflow;

  modport source (output valid, merged_value, source_list, last, overflow, input ready);
  modport sink   (input valid, merged_value, source_list, last, overflow, output ready);
endinterface

@@ hw/rtl/hkm_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module hkm_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/hkm_cfg.sv @@
// APB register slice holding num_lists; also gives the effective list count
// saturated to the list capacity. Depends on hkm_pkg.
module hkm_cfg #(
  parameter int MAX_LISTS = hkm_pkg::MAX_LISTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hkm_pkg::PADDR_W-1:0]   paddr,
  input  logic [hkm_pkg::PDATA_W-1:0]   pwdata,
  output logic [hkm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [$clog2(MAX_LISTS):0]    lists
);
  logic [hkm_pkg::NUML_W-1:0] num_lists;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_lists <= hkm_pkg::NUML_W'(1);
    end else if (psel && penable && pwrite && paddr[2] == hkm_pkg::REG_NUM_LISTS) begin
      num_lists <= pwdata[hkm_pkg::NUML_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == hkm_pkg::REG_NUM_LISTS) ?
                  hkm_pkg::PDATA_W'(num_lists) : '0;
  assign lists  = (int'(num_lists) > MAX_LISTS) ? ($clog2(MAX_LISTS)+1)'(MAX_LISTS)
                                                : ($clog2(MAX_LISTS)+1)'(num_lists);
endmodule

@@ hw/rtl/heap_k_way_merge.sv @@
// Top level of the heap k-way merge block: load sequencer, heap build and
// merge engine. Depends on hkm_pkg, hkm_in_if, hkm_out_if, hkm_ram, hkm_cfg.
//
// Usage: elements arrive on the in_ch word channel, each tagged with its list
// number; every list must arrive in ascending order, lists may interleave.
// A taken load word is written into the element memory, chained behind
// the previous element of its list. The word with final_req set is
// loaded too and then starts the merge; no further input word is taken
// until the merge finishes. The merge first builds a min-heap over the
// heads of the lists: for each list a memory read, then for a non-empty
// list a heap write; then heapify. Each merged word is emitted; when its
// list has more elements, the engine follows the link memory and reads
// the element memory into the root, else the last heap entry moves up
// into the root; a sift-down then moves it down one heap level per step
// (at most log2 of the list count) to its place. Results leave on
// out_ch in ascending order, ties to the lower list; the last word of a merge
// carries last, and every word carries overflow if any element was dropped
// (bad list number or memory full). A stalled receiver stops the engine with
// the pending word held in the output register. Reset clears all control
// state and sets num_lists to 1; the memories need no clearing. After a merge
// all list state clears, num_lists keeps its value.
module heap_k_way_merge #(
  parameter int MAX_LISTS    = hkm_pkg::MAX_LISTS_DEF,
  parameter int MAX_ELEMENTS = hkm_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  hkm_in_if.sink                       in_ch,
  hkm_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hkm_pkg::PADDR_W-1:0]  paddr,
  input  logic [hkm_pkg::PDATA_W-1:0]  pwdata,
  output logic [hkm_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  localparam int LW = $clog2(MAX_LISTS);
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int VW = hkm_pkg::VALUE_W;
  localparam int SW = hkm_pkg::SRC_W;

  hkm_pkg::state_t state, state_next;

  logic [LW:0]   lists;
  logic [AW:0]   fill_count;
  logic          dropped_flag;
  logic [AW-1:0] list_head   [MAX_LISTS];
  logic [AW-1:0] list_tail   [MAX_LISTS];
  logic [AW:0]   list_length [MAX_LISTS];
  logic [VW-1:0] heap_value  [MAX_LISTS];
  logic [SW-1:0] heap_source [MAX_LISTS];
  logic [AW-1:0] heap_cursor [MAX_LISTS];
  logic [LW:0]   heap_size;
  logic [LW:0]   build_idx;
  logic [LW:0]   heapify_k;
  logic [LW-1:0] pos;
  logic          sift_to_merge;

  logic          out_valid;
  logic [VW-1:0] out_value;
  logic [SW-1:0] out_src;
  logic          out_last;
  logic          out_ovf;
  logic          out_free;

  logic          elem_we, link_we;
  logic [AW-1:0] elem_raddr;
  logic [VW-1:0] elem_rdata;
  logic [AW-1:0] link_rdata;

  logic          in_acc;
  logic [LW-1:0] in_idx;
  logic          in_drop;

  logic [LW+1:0] lc, rc;
  logic          use_l, use_r;
  logic [LW-1:0] m_idx, l_idx, r_idx;
  logic [LW-1:0] src_idx;
  logic [LW-1:0] bidx;
  logic          root_more;

  hkm_cfg #(.MAX_LISTS(MAX_LISTS)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .lists
  );

  // Element memory, addressed by load slot.
  hkm_ram #(.W(VW), .DEPTH(MAX_ELEMENTS)) u_elem (
    .clk, .we(elem_we), .waddr(fill_count[AW-1:0]), .wdata(in_ch.value),
    .raddr(elem_raddr), .rdata(elem_rdata)
  );

  // Link memory: slot of the next element of the same list.
  hkm_ram #(.W(AW), .DEPTH(MAX_ELEMENTS)) u_link (
    .clk, .we(link_we), .waddr(list_tail[in_idx]), .wdata(fill_count[AW-1:0]),
    .raddr(heap_cursor[0]), .rdata(link_rdata)
  );

  assign in_ch.ready = (state == hkm_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_idx      = LW'(in_ch.list_id);
  assign in_drop     = (int'(in_ch.list_id) >= int'(lists)) ||
                       (int'(fill_count) >= MAX_ELEMENTS);
  assign elem_we     = in_acc && !in_drop;
  assign link_we     = in_acc && !in_drop && (list_length[in_idx] != '0);
  assign bidx        = build_idx[LW-1:0];
  assign elem_raddr  = (state == hkm_pkg::ST_BLD_RD) ? list_head[bidx] : link_rdata;

  assign out_free    = !out_valid || out_ch.ready;
  assign src_idx     = LW'(heap_source[0]);
  assign root_more   = list_length[src_idx] > (AW+1)'(1);

  // One sift-down step: pick the smallest of the node and its two children.
  assign lc    = {1'b0, pos, 1'b1};
  assign rc    = {1'b0, pos, 1'b0} + (LW+2)'(2);
  assign l_idx = lc[LW-1:0];
  assign r_idx = rc[LW-1:0];
  assign use_l = (lc < (LW+2)'(heap_size)) &&
                 hkm_pkg::entry_before(heap_value[l_idx], heap_source[l_idx],
                                       heap_value[pos], heap_source[pos]);
  always_comb begin
    m_idx = use_l ? l_idx : pos;
    use_r = (rc < (LW+2)'(heap_size)) &&
            hkm_pkg::entry_before(heap_value[r_idx], heap_source[r_idx],
                                  heap_value[m_idx], heap_source[m_idx]);
    if (use_r) begin
      m_idx = r_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hkm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hkm_pkg::ST_IDLE: begin
        if (in_acc && in_ch.final_req) begin
          state_next = hkm_pkg::ST_BLD_RD;
        end
      end
      hkm_pkg::ST_BLD_RD: begin
        if (build_idx == lists) begin
          state_next = hkm_pkg::ST_HEAPIFY;
        end else if (list_length[bidx] != '0) begin
          state_next = hkm_pkg::ST_BLD_WR;
        end
      end
      hkm_pkg::ST_BLD_WR: state_next = hkm_pkg::ST_BLD_RD;
      hkm_pkg::ST_HEAPIFY: begin
        state_next = (heapify_k == '0) ? hkm_pkg::ST_MERGE : hkm_pkg::ST_SIFT;
      end
      hkm_pkg::ST_SIFT: begin
        if (m_idx == pos) begin
          state_next = sift_to_merge ? hkm_pkg::ST_MERGE : hkm_pkg::ST_HEAPIFY;
        end
      end
      hkm_pkg::ST_MERGE: begin
        if (heap_size == '0) begin
          state_next = hkm_pkg::ST_IDLE;
        end else if (out_free) begin
          state_next = root_more ? hkm_pkg::ST_LINK : hkm_pkg::ST_SIFT;
        end
      end
      hkm_pkg::ST_LINK: state_next = hkm_pkg::ST_ELEM;
      hkm_pkg::ST_ELEM: state_next = hkm_pkg::ST_UPD;
      hkm_pkg::ST_UPD:  state_next = hkm_pkg::ST_SIFT;
      default:          state_next = hkm_pkg::ST_IDLE;
    endcase
  end

  // Control counters and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      dropped_flag <= 1'b0;
      heap_size    <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < MAX_LISTS; i++) begin
        list_length[i] <= '0;
      end
    end else begin
      // A new word enters the output register when the engine emits one;
      // otherwise a taken word leaves it.
      if (state == hkm_pkg::ST_MERGE && heap_size != '0 && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        hkm_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (in_drop) begin
              dropped_flag <= 1'b1;
            end else begin
              list_length[in_idx] <= list_length[in_idx] + (AW+1)'(1);
              fill_count          <= fill_count + (AW+1)'(1);
            end
            if (in_ch.final_req) begin
              heap_size <= '0;
            end
          end
        end
        hkm_pkg::ST_BLD_WR: heap_size <= heap_size + (LW+1)'(1);
        hkm_pkg::ST_MERGE: begin
          if (heap_size == '0) begin
            fill_count   <= '0;
            dropped_flag <= 1'b0;
            for (int i = 0; i < MAX_LISTS; i++) begin
              list_length[i] <= '0;
            end
          end else if (out_free) begin
            if (!root_more) begin
              list_length[src_idx] <= '0;
              heap_size            <= heap_size - (LW+1)'(1);
            end
          end
        end
        hkm_pkg::ST_UPD: list_length[src_idx] <= list_length[src_idx] - (AW+1)'(1);
        default: ;
      endcase
    end
  end

  // Datapath: list pointers, heap entries and the output register.
  always_ff @(posedge clk) begin
    case (state)
      hkm_pkg::ST_IDLE: begin
        if (in_acc && !in_drop) begin
          if (list_length[in_idx] == '0) begin
            list_head[in_idx] <= fill_count[AW-1:0];
          end
          list_tail[in_idx] <= fill_count[AW-1:0];
        end
        build_idx <= '0;
      end
      hkm_pkg::ST_BLD_RD: begin
        if (build_idx == lists) begin
          heapify_k <= heap_size >> 1;
        end else if (list_length[bidx] == '0) begin
          build_idx <= build_idx + (LW+1)'(1);
        end
      end
      hkm_pkg::ST_BLD_WR: begin
        heap_value[heap_size[LW-1:0]]  <= elem_rdata;
        heap_source[heap_size[LW-1:0]] <= SW'(build_idx);
        heap_cursor[heap_size[LW-1:0]] <= list_head[bidx];
        build_idx                      <= build_idx + (LW+1)'(1);
      end
      hkm_pkg::ST_HEAPIFY: begin
        if (heapify_k != '0) begin
          pos           <= LW'(heapify_k - (LW+1)'(1));
          heapify_k     <= heapify_k - (LW+1)'(1);
          sift_to_merge <= 1'b0;
        end
      end
      hkm_pkg::ST_SIFT: begin
        if (m_idx != pos) begin
          heap_value[pos]    <= heap_value[m_idx];
          heap_source[pos]   <= heap_source[m_idx];
          heap_cursor[pos]   <= heap_cursor[m_idx];
          heap_value[m_idx]  <= heap_value[pos];
          heap_source[m_idx] <= heap_source[pos];
          heap_cursor[m_idx] <= heap_cursor[pos];
          pos                <= m_idx;
        end
      end
      hkm_pkg::ST_MERGE: begin
        if (heap_size != '0 && out_free) begin
          out_value     <= heap_value[0];
          out_src       <= heap_source[0];
          out_ovf       <= dropped_flag;
          out_last      <= !root_more && (heap_size == (LW+1)'(1));
          pos           <= '0;
          sift_to_merge <= 1'b1;
          if (!root_more) begin
            // The last heap entry moves up into the root.
            heap_value[0]  <= heap_value[LW'(heap_size - (LW+1)'(1))];
            heap_source[0] <= heap_source[LW'(heap_size - (LW+1)'(1))];
            heap_cursor[0] <= heap_cursor[LW'(heap_size - (LW+1)'(1))];
          end
        end
      end
      hkm_pkg::ST_UPD: begin
        heap_value[0]  <= elem_rdata;
        heap_cursor[0] <= link_rdata;
        pos            <= '0;
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.merged_value = out_value;
  assign out_ch.source_list  = out_src;
  assign out_ch.last         = out_last;
  assign out_ch.overflow     = out_ovf;

  // The load never runs past the element memory.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill_count) <= MAX_ELEMENTS)
    else $error("fill count exceeds element capacity");

  // The heap never holds more entries than lists.
  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    heap_size <= lists)
    else $error("heap larger than list count");

  // A sift step works on a node inside the heap, unless the heap has emptied.
  a_sift_pos: assert property (@(posedge clk) disable iff (rst)
    state == hkm_pkg::ST_SIFT |-> (LW+1)'(pos) < heap_size || heap_size == '0)
    else $error("sift position outside heap");

  // Returning to idle from the merge leaves the load state cleared.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    state == hkm_pkg::ST_IDLE && $past(state) == hkm_pkg::ST_MERGE
    |-> fill_count == '0 && !dropped_flag)
    else $error("load state not cleared after merge");

  // A result is only produced while the heap holds entries.
  a_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == hkm_pkg::ST_MERGE)
    else $error("result word produced outside merge");
endmodule

@@ tb/hkm_merge_checker.sv @@
// Scoreboard for the heap k-way merge block: watches the input, output and
// register ports, predicts every merged word and compares it field by field.
// Depends on hkm_pkg, hkm_in_if and hkm_out_if.
module hkm_merge_checker (
  input  logic                        clk,
  input  logic                        rst,
  hkm_in_if                           in_ch,
  hkm_out_if                          out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [hkm_pkg::PADDR_W-1:0] paddr,
  input  logic [hkm_pkg::PDATA_W-1:0] pwdata,
  output int                          error_count,
  output int                          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LISTS = hkm_pkg::MAX_LISTS_DEF;
  localparam int SLOTS = hkm_pkg::MAX_ELEMENTS_DEF;

  typedef struct packed {
    logic [hkm_pkg::VALUE_W-1:0] merged_value;
    logic [hkm_pkg::SRC_W-1:0]   source_list;
    logic                        last;
    logic                        overflow;
  } merged_word_t;

  logic [hkm_pkg::NUML_W-1:0]  num_lists;
  logic [hkm_pkg::VALUE_W-1:0] loaded_lists[LISTS][$];
  int                          fill_count;
  logic                        dropped;
  merged_word_t                merged_words[$];

  assign words_pending = merged_words.size();

  // Stable merge of the loaded lists: smallest value first, ties to the
  // lower list number, which is what the heap order gives for sorted lists.
  task automatic merge_loaded_lists();
    merged_word_t w;
    int           pick;
    int           total;
    total = 0;
    for (int l = 0; l < LISTS; l++) total += loaded_lists[l].size();
    while (total > 0) begin
      pick = -1;
      for (int l = 0; l < LISTS; l++) begin
        if (loaded_lists[l].size() != 0) begin
          if (pick < 0 ||
              $signed(loaded_lists[l][0]) < $signed(loaded_lists[pick][0])) begin
            pick = l;
          end
        end
      end
      w.merged_value = loaded_lists[pick].pop_front();
      w.source_list  = pick[hkm_pkg::SRC_W-1:0];
      total--;
      w.last         = (total == 0);
      w.overflow     = dropped;
      merged_words.push_back(w);
    end
    fill_count = 0;
    dropped    = 1'b0;
  endtask

  task automatic load_element(input logic [hkm_pkg::SRC_W-1:0] id,
                              input logic [hkm_pkg::VALUE_W-1:0] val,
                              input logic fin);
    int lists;
    lists = (num_lists > LISTS) ? LISTS : int'(num_lists);
    if (int'(id) >= lists || fill_count >= SLOTS) begin
      dropped = 1'b1;
    end else begin
      loaded_lists[id].push_back(val);
      fill_count++;
    end
    if (fin) merge_loaded_lists();
  endtask

  task automatic check_word(input merged_word_t got);
    merged_word_t exp_w;
    if (merged_words.size() == 0) begin
      $error("unexpected merged word: value %0d list %0d", $signed(got.merged_value),
             got.source_list);
      error_count++;
    end else begin
      exp_w = merged_words.pop_front();
      if (got.merged_value !== exp_w.merged_value) begin
        $error("merged_value: expected %0d, got %0d", $signed(exp_w.merged_value),
               $signed(got.merged_value));
        error_count++;
      end
      if (got.source_list !== exp_w.source_list) begin
        $error("source_list: expected %0d, got %0d", exp_w.source_list, got.source_list);
        error_count++;
      end
      if (got.last !== exp_w.last) begin
        $error("last: expected %0b, got %0b", exp_w.last, got.last);
        error_count++;
      end
      if (got.overflow !== exp_w.overflow) begin
        $error("overflow: expected %0b, got %0b", exp_w.overflow, got.overflow);
        error_count++;
      end
    end
  endtask

  initial error_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      num_lists  = 1;
      fill_count = 0;
      dropped    = 1'b0;
      for (int l = 0; l < LISTS; l++) loaded_lists[l].delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == hkm_pkg::REG_NUM_LISTS) begin
        num_lists = pwdata[hkm_pkg::NUML_W-1:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        check_word({out_ch.merged_value, out_ch.source_list, out_ch.last, out_ch.overflow});
      end
      if (in_ch.valid && in_ch.ready) load_element(in_ch.list_id, in_ch.value, in_ch.final_req);
    end
  end

  final begin
    if (merged_words.size() != 0) begin
      $error("%0d merged words never arrived", merged_words.size());
    end
  end
endmodule

@@ tb/heap_k_way_merge_test.sv @@
// Testbench top for the heap k-way merge block: clock, reset, register
// writes, load stimulus and the verdict. Depends on hkm_pkg, the channel
// interfaces, hkm_merge_checker and the block itself.
module heap_k_way_merge_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [hkm_pkg::PADDR_W-1:0] paddr;
  logic [hkm_pkg::PDATA_W-1:0] pwdata;
  logic [hkm_pkg::PDATA_W-1:0] prdata;
  logic pready;

  int error_count;
  int words_pending;
  int cycle_count;
  int items_sent;
  int gap_pct;
  int stall_pct;
  logic [hkm_pkg::NUML_W-1:0] lists_now;

  hkm_in_if  in_ch ();
  hkm_out_if out_ch ();

  heap_k_way_merge dut (
    .clk, .rst, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hkm_merge_checker checker_i (
    .clk, .rst, .in_ch, .out_ch,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .error_count, .words_pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run is cut off if the block hangs; a correct run ends far sooner.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver stalls at the rate set by the current phase.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Register write: setup cycle, then the access cycle in which
  // the register takes the data.
  task automatic write_num_lists(input int n);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {hkm_pkg::REG_NUM_LISTS, 2'b00};
    pwdata  <= hkm_pkg::PDATA_W'(n);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    lists_now = hkm_pkg::NUML_W'(n);
  endtask

  // Offer one word, idling first at the phase's rate, and hold it until the
  // block takes it. Valid stays high into the next word when there is no gap.
  task automatic send_word(input int id, input logic [hkm_pkg::VALUE_W-1:0] val,
                           input logic fin);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.list_id   <= hkm_pkg::SRC_W'(id);
    in_ch.value     <= val;
    in_ch.final_req <= fin;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Registers change only once the block has gone quiet: every expected
  // word has arrived, and a final word with nothing loaded may still be
  // clearing state inside the block.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One load of n words ending in the merge request. Each list stays
  // ascending. With narrow values the lists crowd together and ties are
  // common; otherwise the first element of a list spans the full range.
  task automatic load_and_merge(input int n, input int bad_pct, input int narrow);
    longint tail_val[8];
    bit     started[8];
    int     lists;
    int     id;
    longint v;
    lists = (lists_now > 8) ? 8 : int'(lists_now);
    for (int l = 0; l < 8; l++) started[l] = 0;
    for (int k = 0; k < n; k++) begin
      if (lists == 0 || $urandom_range(99) < bad_pct) id = $urandom_range(7);
      else id = $urandom_range(lists - 1);
      if (!started[id]) begin
        v = (narrow != 0) ? longint'($urandom_range(8)) - 4 : longint'($signed($urandom));
      end else if (narrow != 0) begin
        v = tail_val[id] + $urandom_range(2);
      end else begin
        v = tail_val[id] + ($urandom >> $urandom_range(31));
      end
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      // A dropped word does not join its list, so it need not stay in order.
      if (id < lists) begin
        tail_val[id] = v;
        started[id]  = 1;
      end
      send_word(id, v[hkm_pkg::VALUE_W-1:0], k == n - 1);
    end
  endtask

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.list_id   = '0;
    in_ch.value     = '0;
    in_ch.final_req = 1'b0;
    out_ch.ready    = 1'b0;
    cycle_count     = 0;
    items_sent      = 0;
    gap_pct         = 0;
    stall_pct       = 0;
    lists_now       = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. The extremes of the value range, equal heads in
    // several lists, and the highest list number.
    write_num_lists(8);
    send_word(0, 32'h8000_0000, 1'b0);
    send_word(7, 32'h7fff_ffff, 1'b0);
    send_word(3, 32'd5, 1'b0);
    send_word(5, 32'd5, 1'b0);
    send_word(0, 32'd5, 1'b0);
    send_word(3, 32'd5, 1'b0);
    send_word(1, 32'hffff_ffff, 1'b0);
    send_word(7, 32'h7fff_ffff, 1'b1);
    wait_idle();

    // A list number at or above the list count is dropped and flagged,
    // and a dropped final word still starts the merge.
    write_num_lists(3);
    send_word(2, 32'd10, 1'b0);
    send_word(5, 32'd1, 1'b0);
    send_word(0, 32'd11, 1'b0);
    send_word(4, 32'd3, 1'b1);
    wait_idle();

    // With zero lists everything is dropped: nothing loaded, nothing out.
    write_num_lists(0);
    send_word(0, 32'd7, 1'b0);
    send_word(0, 32'd8, 1'b1);
    wait_idle();

    // Counts above the list limit saturate; a lone final with one element.
    write_num_lists(15);
    send_word(6, 32'd42, 1'b1);
    wait_idle();

    // Memory full: more words than slots, the surplus is dropped.
    write_num_lists(8);
    load_and_merge(70, 0, 0);
    wait_idle();

    // Random part in phases of sender and receiver idling. Most loads are
    // clean with random content; some carry bad list numbers.
    for (int batch = 0; items_sent < 480; batch++) begin
      case (batch % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 6; stall_pct = 6; end
      endcase
      if (batch % 5 == 0) begin
        wait_idle();
        case ($urandom_range(9))
          0:       write_num_lists(1);
          1:       write_num_lists(15);
          2:       write_num_lists($urandom_range(9, 14));
          default: write_num_lists($urandom_range(2, 8));
        endcase
      end
      if ($urandom_range(19) == 0) load_and_merge($urandom_range(50, 68), 3, $urandom_range(1));
      else load_and_merge($urandom_range(1, 16), ($urandom_range(3) == 0) ? 15 : 0,
                          $urandom_range(1));
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
